// ===== design/vfpi_pkg.sv =====
// Shared types, register indexes and reset constants of the velocity filter and PI controller.
package vfpi_pkg;

    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 3;

    typedef struct packed {
        logic signed [WORD_W-1:0] shaft_speed;
        logic                     shaft_present;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] filtered_speed;
        logic signed [WORD_W-1:0] drive_effort;
    } out_word_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REFERENCE_SPEED  = 3'd0,
        CFG_FILTER_GAIN_NOW  = 3'd1,
        CFG_FILTER_GAIN_PREV = 3'd2,
        CFG_FILTER_FEEDBACK  = 3'd3,
        CFG_CTL_FEEDBACK     = 3'd4,
        CFG_CTL_GAIN_NOW     = 3'd5,
        CFG_CTL_GAIN_PREV    = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_FSUM,
        S_ERR,
        S_CTL,
        S_CSUM
    } state_t;

    typedef enum logic [1:0] {
        TAP_FEEDBACK,
        TAP_NOW,
        TAP_PREV
    } tap_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic add;
    } mac_ctl_t;

    localparam logic signed [WORD_W-1:0] REFERENCE_SPEED_RST  = 32'sd0;
    localparam logic signed [WORD_W-1:0] FILTER_GAIN_NOW_RST  = 32'sd10382;
    localparam logic signed [WORD_W-1:0] FILTER_GAIN_PREV_RST = 32'sd10382;
    localparam logic signed [WORD_W-1:0] FILTER_FEEDBACK_RST  = 32'sd1027814;
    localparam logic signed [WORD_W-1:0] CTL_FEEDBACK_RST     = 32'sd1048576;
    localparam logic signed [WORD_W-1:0] CTL_GAIN_NOW_RST     = 32'sd215272653;
    localparam logic signed [WORD_W-1:0] CTL_GAIN_PREV_RST    = -32'sd215167795;

endpackage

// ===== design/vfpi_mac.sv =====
// Shared multiplier and accumulator with floor shift and output saturation.
module vfpi_mac #(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                    aclk,
    input  vfpi_pkg::mac_ctl_t      ctl,
    input  logic signed [31:0]      op_val,
    input  logic signed [31:0]      op_coef,
    output logic signed [31:0]      sum_sat
);
    import vfpi_pkg::*;

    localparam int VAL_BITS   = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
    localparam int FRAC_SHIFT = COEF_FRAC_BITS % 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int ACC_W      = PROD_W - FRAC_SHIFT + 2;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    total;
    logic                       overflow;
    logic signed [VAL_BITS-1:0] sat_val;

    assign prod_next = PROD_W'(op_val) * PROD_W'(op_coef);
    assign term      = ACC_W'(prod_reg >>> FRAC_SHIFT);
    assign total     = acc_reg + term;

    always_comb begin
        if (ctl.start) begin
            acc_next = '0;
        end else if (ctl.add) begin
            acc_next = total;
        end else begin
            acc_next = acc_reg;
        end
    end

    assign overflow = (total[ACC_W-1:VAL_BITS-1] != {(ACC_W-VAL_BITS+1){total[ACC_W-1]}});

    always_comb begin
        if (!overflow) begin
            sat_val = total[VAL_BITS-1:0];
        end else if (total[ACC_W-1]) begin
            sat_val = {1'b1, {(VAL_BITS-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(VAL_BITS-1){1'b1}}};
        end
    end

    assign sum_sat = 32'(sat_val);

    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

endmodule

// ===== design/velocity_filter_pi_controller.sv =====
// Velocity low-pass filter followed by an incremental PI controller, top level.
// A word with the present flag set runs the filter and then the controller; the next word
// waits until that result is committed, as the single multiplier-accumulator forms all six
// products in turn, the error step between them. A word with the flag clear is dropped.
// Reset is synchronous, active low: coefficients return to defaults, history and valid clear.
module velocity_filter_pi_controller #(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  vfpi_pkg::in_word_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output vfpi_pkg::out_word_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vfpi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);
    import vfpi_pkg::*;

    localparam int VAL_BITS = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    logic signed [WORD_W-1:0]   reference_speed_reg;
    logic signed [WORD_W-1:0]   filter_gain_now_reg;
    logic signed [WORD_W-1:0]   filter_gain_prev_reg;
    logic signed [WORD_W-1:0]   filter_feedback_reg;
    logic signed [WORD_W-1:0]   ctl_feedback_reg;
    logic signed [WORD_W-1:0]   ctl_gain_now_reg;
    logic signed [WORD_W-1:0]   ctl_gain_prev_reg;

    logic signed [VAL_BITS-1:0] prev_sample_reg;
    logic signed [VAL_BITS-1:0] prev_filtered_reg;
    logic signed [VAL_BITS-1:0] prev_error_reg;
    logic signed [VAL_BITS-1:0] prev_effort_reg;
    logic signed [VAL_BITS-1:0] x_reg;
    logic signed [VAL_BITS-1:0] y_reg;
    logic signed [VAL_BITS-1:0] e_reg;

    state_t                     state_reg;
    state_t                     state_next;
    tap_t                       tap_reg;
    tap_t                       tap_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    out_word_t                  out_reg;

    mac_ctl_t                   mac_ctl;
    logic signed [WORD_W-1:0]   op_val;
    logic signed [WORD_W-1:0]   op_coef;
    logic signed [WORD_W-1:0]   sum_sat;
    logic                       load_x;
    logic                       load_y;
    logic                       load_e;
    logic                       commit;

    logic signed [WORD_W:0]     sat_src;
    logic                       sat_ovf;
    logic signed [VAL_BITS-1:0] sat_res;

    vfpi_mac #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .ctl     (mac_ctl),
        .op_val  (op_val),
        .op_coef (op_coef),
        .sum_sat (sum_sat)
    );

    // One saturator serves the incoming sample and the controller error.
    assign sat_src = (state_reg == S_IDLE) ? (WORD_W+1)'(s_data.shaft_speed)
                   : (WORD_W+1)'(reference_speed_reg) - (WORD_W+1)'(y_reg);
    assign sat_ovf = (sat_src[WORD_W:VAL_BITS-1] != {(WORD_W-VAL_BITS+2){sat_src[WORD_W]}});

    always_comb begin
        if (!sat_ovf) begin
            sat_res = sat_src[VAL_BITS-1:0];
        end else if (sat_src[WORD_W]) begin
            sat_res = {1'b1, {(VAL_BITS-1){1'b0}}};
        end else begin
            sat_res = {1'b0, {(VAL_BITS-1){1'b1}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        tap_next   = TAP_FEEDBACK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_data.shaft_present) begin
                    state_next = S_FILT;
                end
            end
            S_FILT: begin
                case (tap_reg)
                    TAP_FEEDBACK: tap_next = TAP_NOW;
                    TAP_NOW:      tap_next = TAP_PREV;
                    default:      state_next = S_FSUM;
                endcase
            end
            S_FSUM: state_next = S_ERR;
            S_ERR:  state_next = S_CTL;
            S_CTL: begin
                case (tap_reg)
                    TAP_FEEDBACK: tap_next = TAP_NOW;
                    TAP_NOW:      tap_next = TAP_PREV;
                    default:      state_next = S_CSUM;
                endcase
            end
            S_CSUM: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl = '0;
        op_val  = 32'(prev_filtered_reg);
        op_coef = filter_feedback_reg;
        load_x  = 1'b0;
        load_y  = 1'b0;
        load_e  = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            S_IDLE: load_x = s_valid;
            S_FILT: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.start = (tap_reg == TAP_FEEDBACK);
                mac_ctl.add   = (tap_reg != TAP_FEEDBACK);
                case (tap_reg)
                    TAP_FEEDBACK: begin
                        op_val  = 32'(prev_filtered_reg);
                        op_coef = filter_feedback_reg;
                    end
                    TAP_NOW: begin
                        op_val  = 32'(x_reg);
                        op_coef = filter_gain_now_reg;
                    end
                    default: begin
                        op_val  = 32'(prev_sample_reg);
                        op_coef = filter_gain_prev_reg;
                    end
                endcase
            end
            S_FSUM: load_y = 1'b1;
            S_ERR:  load_e = 1'b1;
            S_CTL: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.start = (tap_reg == TAP_FEEDBACK);
                mac_ctl.add   = (tap_reg != TAP_FEEDBACK);
                case (tap_reg)
                    TAP_FEEDBACK: begin
                        op_val  = 32'(prev_effort_reg);
                        op_coef = ctl_feedback_reg;
                    end
                    TAP_NOW: begin
                        op_val  = 32'(e_reg);
                        op_coef = ctl_gain_now_reg;
                    end
                    default: begin
                        op_val  = 32'(prev_error_reg);
                        op_coef = ctl_gain_prev_reg;
                    end
                endcase
            end
            S_CSUM: commit = !m_valid_reg || m_ready;
            default: commit = 1'b0;
        endcase
    end

    always_comb begin
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            tap_reg              <= TAP_FEEDBACK;
            m_valid_reg          <= 1'b0;
            reference_speed_reg  <= REFERENCE_SPEED_RST;
            filter_gain_now_reg  <= FILTER_GAIN_NOW_RST;
            filter_gain_prev_reg <= FILTER_GAIN_PREV_RST;
            filter_feedback_reg  <= FILTER_FEEDBACK_RST;
            ctl_feedback_reg     <= CTL_FEEDBACK_RST;
            ctl_gain_now_reg     <= CTL_GAIN_NOW_RST;
            ctl_gain_prev_reg    <= CTL_GAIN_PREV_RST;
            prev_sample_reg      <= '0;
            prev_filtered_reg    <= '0;
            prev_error_reg       <= '0;
            prev_effort_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_REFERENCE_SPEED:  reference_speed_reg  <= cfg_data;
                    CFG_FILTER_GAIN_NOW:  filter_gain_now_reg  <= cfg_data;
                    CFG_FILTER_GAIN_PREV: filter_gain_prev_reg <= cfg_data;
                    CFG_FILTER_FEEDBACK:  filter_feedback_reg  <= cfg_data;
                    CFG_CTL_FEEDBACK:     ctl_feedback_reg     <= cfg_data;
                    CFG_CTL_GAIN_NOW:     ctl_gain_now_reg     <= cfg_data;
                    CFG_CTL_GAIN_PREV:    ctl_gain_prev_reg    <= cfg_data;
                    default:              ;
                endcase
            end
            if (commit) begin
                prev_sample_reg   <= x_reg;
                prev_filtered_reg <= y_reg;
                prev_error_reg    <= e_reg;
                prev_effort_reg   <= sum_sat[VAL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_x) begin
            x_reg <= sat_res;
        end
        if (load_y) begin
            y_reg <= sum_sat[VAL_BITS-1:0];
        end
        if (load_e) begin
            e_reg <= sat_res;
        end
        if (commit) begin
            out_reg.filtered_speed <= 32'(y_reg);
            out_reg.drive_effort   <= sum_sat;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

`ifndef SYNTH
    a_result_from_final_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_CSUM))
        else $error("Result word appeared without finishing the controller step.");

    a_present_starts_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.shaft_present |=> state_reg == S_FILT)
        else $error("Accepted sample did not start the filter sequence.");

    a_absent_keeps_history: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.shaft_present
        |=> state_reg == S_IDLE && $stable(prev_sample_reg) && $stable(prev_effort_reg))
        else $error("Absent sample changed the controller history.");

    a_hold_while_output_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CSUM && m_valid && !m_ready |=> state_reg == S_CSUM)
        else $error("Finished result overwrote a word still waiting at the output.");
`endif

endmodule
